### design/lbrp_pkg.sv
// Package for the lifetime buffer reuse planner.
// Holds field widths, register indexes, error codes, sequencer states and the
// structs shared by the planner modules. Depends on nothing.
package lbrp_pkg;

   localparam int ID_W        = 9;
   localparam int SIZE_W      = 32;
   localparam int TIME_W      = 16;
   localparam int TOTAL_W     = 48;
   localparam int SRC_W       = 12;
   localparam int COUNT_W     = 9;
   localparam int CODE_W      = 3;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 48;
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 104;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_DESTRUCTIVE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BASE_TOTAL  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BASE_COUNT  = 2'd2;

   typedef enum logic [CODE_W-1:0] {
      ERR_NONE,
      ERR_DUP_FREE,
      ERR_BAD_SRC,
      ERR_SRC_SMALL,
      ERR_GROW,
      ERR_OVERFLOW,
      ERR_INCONSISTENT,
      ERR_HALTED
   } err_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_LRD,
      ST_LCHK,
      ST_CONS,
      ST_DRD,
      ST_DCHK,
      ST_PLACE,
      ST_ORD,
      ST_BRD,
      ST_FRD,
      ST_FCHK,
      ST_ALLOC,
      ST_REMRD,
      ST_REMWR,
      ST_FIN,
      ST_FCK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic               new_plan;
      logic [ID_W-1:0]    buffer_id;
      logic [SIZE_W-1:0]  request_bytes;
      logic [TIME_W-1:0]  first_use;
      logic [TIME_W-1:0]  last_use;
      logic [SRC_W-1:0]   source_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]    owner_id;
      logic [SIZE_W-1:0]  granted_bytes;
      logic [TOTAL_W-1:0] total_bytes;
      logic [COUNT_W-1:0] block_count;
      err_type            error_code;
   } rsp_type;

   typedef struct packed {
      logic               destructive_mode;
      logic [TOTAL_W-1:0] base_total_bytes;
      logic [COUNT_W-1:0] base_block_count;
   } cfg_type;

   // One entry of the live table.
   typedef struct packed {
      logic [TIME_W-1:0]  last_use;
      logic [ID_W-1:0]    buffer;
      logic [ID_W-1:0]    owner;
      logic [SIZE_W-1:0]  capacity;
   } live_type;

   // One entry of the free set.
   typedef struct packed {
      logic [SIZE_W-1:0]  capacity;
      logic [ID_W-1:0]    owner;
   } free_type;

endpackage

### design/lbrp_ram.sv
// Simple dual-port synchronous RAM for the planner tables.
// One write port and one read port with registered read data.
// Depends on nothing.
module lbrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### design/lbrp_ctrl.sv
// Sequencer and datapath of the planner: retire pass, free-set search,
// in-place reuse and table updates over five synchronous memories.
// Depends on lbrp_pkg and lbrp_ram.
module lbrp_ctrl
   import lbrp_pkg::*;
#(
   parameter int MAX_BUFFERS = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam int AW     = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
   localparam int CW     = $clog2(MAX_BUFFERS + 1);
   localparam int LIMW   = SRC_W + 1;
   localparam int SUMW   = TOTAL_W + 1;
   localparam int LIVE_W = $bits(live_type);
   localparam int FREE_W = $bits(free_type);
   localparam logic [CW-1:0]   CNT_MAX  = CW'(MAX_BUFFERS);
   localparam logic [AW-1:0]   IDX_LAST = AW'(MAX_BUFFERS - 1);
   localparam logic [LIMW-1:0] ID_LIMIT = LIMW'(MAX_BUFFERS);

   state_type state_ff, state_in;
   logic [CW-1:0] i_ff, i_in, k_ff, k_in, j_ff, j_in, lc_ff, lc_in, fc_ff, fc_in;
   logic [AW-1:0] clr_ff, clr_in, rem_ff, rem_in;
   logic pend_ff, pend_in;
   req_type req_ff, req_in;
   live_type ent_ff, ent_in;
   logic [ID_W-1:0] owner_ff, owner_in;
   logic [SIZE_W-1:0] cap_ff, cap_in;
   logic best_v_ff, best_v_in, big_v_ff, big_v_in;
   logic [AW-1:0] best_idx_ff, best_idx_in, big_idx_ff, big_idx_in;
   logic [SIZE_W-1:0] best_cap_ff, best_cap_in, big_cap_ff, big_cap_in;
   logic [ID_W-1:0] best_own_ff, best_own_in, big_own_ff, big_own_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   err_type sticky_ff, sticky_in, res_code_ff, res_code_in;
   logic [ID_W-1:0] res_owner_ff, res_owner_in;
   logic [SIZE_W-1:0] res_cap_ff, res_cap_in;

   // Memory ports.
   logic live_we, free_we, book_we, own_we, cons_we;
   logic [AW-1:0] live_waddr, live_raddr, free_waddr, free_raddr;
   logic [AW-1:0] book_waddr, book_raddr, own_waddr, own_raddr, cons_waddr, cons_raddr;
   live_type live_wdata;
   free_type free_wdata;
   logic [SIZE_W-1:0] book_wdata, book_q;
   logic [ID_W-1:0] own_wdata, own_q;
   logic cons_wdata, cons_q;
   logic [LIVE_W-1:0] live_rdata;
   logic [FREE_W-1:0] free_rdata;
   live_type live_q;
   free_type free_q;

   // Decisions.
   logic i_end, j_end, kept, dup_hit, dest, src_bad, id_bad, grow;
   logic fit, better_best, better_big, sum_ovf, fail;
   logic [SIZE_W-1:0] delta;
   logic [SUMW-1:0] sum;
   logic [CW-1:0] fc_dec;
   err_type fail_code;

   lbrp_ram #(.WIDTH(LIVE_W), .DEPTH(MAX_BUFFERS)) u_live (
      .clock(clock), .we(live_we), .waddr(live_waddr), .wdata(live_wdata),
      .raddr(live_raddr), .rdata(live_rdata));
   lbrp_ram #(.WIDTH(FREE_W), .DEPTH(MAX_BUFFERS)) u_free (
      .clock(clock), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
      .raddr(free_raddr), .rdata(free_rdata));
   lbrp_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_BUFFERS)) u_book (
      .clock(clock), .we(book_we), .waddr(book_waddr), .wdata(book_wdata),
      .raddr(book_raddr), .rdata(book_q));
   lbrp_ram #(.WIDTH(ID_W), .DEPTH(MAX_BUFFERS)) u_own (
      .clock(clock), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
      .raddr(own_raddr), .rdata(own_q));
   lbrp_ram #(.WIDTH(1), .DEPTH(MAX_BUFFERS)) u_cons (
      .clock(clock), .we(cons_we), .waddr(cons_waddr), .wdata(cons_wdata),
      .raddr(cons_raddr), .rdata(cons_q));

   assign live_q = live_type'(live_rdata);
   assign free_q = free_type'(free_rdata);

   // Comparisons shared by the sequencer and the datapath.
   assign i_end   = (i_ff == lc_ff);
   assign j_end   = (j_ff == fc_ff);
   assign kept    = (live_q.last_use >= req_ff.first_use);
   assign dup_hit = (free_q.capacity == ent_ff.capacity) && (free_q.owner == ent_ff.owner);
   assign dest    = cfg.destructive_mode && (req_ff.source_id != '0);
   assign src_bad = (LIMW'(req_ff.source_id) > ID_LIMIT);
   assign id_bad  = (req_ff.buffer_id == '0) || (LIMW'(req_ff.buffer_id) > ID_LIMIT);
   assign grow    = (fc_ff != '0);
   assign fc_dec  = fc_ff - 1'b1;

   // Free-set search: smallest fitting block and largest block.
   assign fit         = (free_q.capacity >= req_ff.request_bytes);
   assign better_best = fit && (!best_v_ff || (free_q.capacity < best_cap_ff) ||
                        ((free_q.capacity == best_cap_ff) && (free_q.owner < best_own_ff)));
   assign better_big  = !big_v_ff || (free_q.capacity > big_cap_ff) ||
                        ((free_q.capacity == big_cap_ff) && (free_q.owner > big_own_ff));

   // Running total with saturation detection.
   assign delta   = grow ? (req_ff.request_bytes - big_cap_ff) : req_ff.request_bytes;
   assign sum     = {1'b0, total_ff} + SUMW'(delta);
   assign sum_ovf = sum[TOTAL_W];

   // Failure detection per step.
   always_comb begin
      fail      = 1'b0;
      fail_code = ERR_NONE;
      unique case (state_ff)
         ST_START: begin
            if (sticky_ff != ERR_NONE) begin
               fail      = 1'b1;
               fail_code = ERR_HALTED;
            end else if (id_bad) begin
               fail      = 1'b1;
               fail_code = ERR_INCONSISTENT;
            end
         end
         ST_DRD: begin
            if (j_end && (fc_ff == CNT_MAX)) begin
               fail      = 1'b1;
               fail_code = ERR_INCONSISTENT;
            end
         end
         ST_DCHK: begin
            if (dup_hit) begin
               fail      = 1'b1;
               fail_code = ERR_DUP_FREE;
            end
         end
         ST_PLACE: begin
            if (dest && src_bad) begin
               fail      = 1'b1;
               fail_code = ERR_BAD_SRC;
            end
         end
         ST_ORD: begin
            if (own_q == '0) begin
               fail      = 1'b1;
               fail_code = ERR_BAD_SRC;
            end
         end
         ST_BRD: begin
            if (book_q < req_ff.request_bytes) begin
               fail      = 1'b1;
               fail_code = ERR_SRC_SMALL;
            end
         end
         ST_ALLOC: begin
            if (!best_v_ff && grow) begin
               if (big_cap_ff >= req_ff.request_bytes) begin
                  fail      = 1'b1;
                  fail_code = ERR_GROW;
               end else if (sum_ovf) begin
                  fail      = 1'b1;
                  fail_code = ERR_OVERFLOW;
               end
            end else if (!best_v_ff) begin
               if (sum_ovf || (count_ff == COUNT_MAX)) begin
                  fail      = 1'b1;
                  fail_code = ERR_OVERFLOW;
               end
            end
         end
         ST_FCK: begin
            if ((owner_ff == '0) || (cap_ff == '0) || (book_q != cap_ff) ||
                (lc_ff == CNT_MAX)) begin
               fail      = 1'b1;
               fail_code = ERR_INCONSISTENT;
            end
         end
         default: ;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == IDX_LAST) state_in = pend_ff ? ST_START : ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = req.new_plan ? ST_CLEAR : ST_START;
         ST_START: state_in = fail ? ST_EMIT : ST_LRD;
         ST_LRD:   state_in = i_end ? ST_PLACE : ST_LCHK;
         ST_LCHK:  state_in = kept ? ST_LRD : ST_CONS;
         ST_CONS:  state_in = cons_q ? ST_LRD : ST_DRD;
         ST_DRD: begin
            if (fail) state_in = ST_EMIT;
            else if (j_end) state_in = ST_LRD;
            else state_in = ST_DCHK;
         end
         ST_DCHK:  state_in = fail ? ST_EMIT : ST_DRD;
         ST_PLACE: begin
            if (fail) state_in = ST_EMIT;
            else if (dest) state_in = ST_ORD;
            else state_in = ST_FRD;
         end
         ST_ORD:   state_in = fail ? ST_EMIT : ST_BRD;
         ST_BRD:   state_in = fail ? ST_EMIT : ST_FIN;
         ST_FRD:   state_in = j_end ? ST_ALLOC : ST_FCHK;
         ST_FCHK:  state_in = ST_FRD;
         ST_ALLOC: begin
            if (fail) state_in = ST_EMIT;
            else if (best_v_ff || grow) state_in = ST_REMRD;
            else state_in = ST_FIN;
         end
         ST_REMRD: state_in = ST_REMWR;
         ST_REMWR: state_in = ST_FIN;
         ST_FIN:   state_in = ST_FCK;
         ST_FCK:   state_in = ST_EMIT;
         ST_EMIT:  if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory accesses.
   always_comb begin
      i_in = i_ff; k_in = k_ff; j_in = j_ff; lc_in = lc_ff; fc_in = fc_ff;
      clr_in = clr_ff; rem_in = rem_ff; pend_in = pend_ff;
      req_in = req_ff; ent_in = ent_ff; owner_in = owner_ff; cap_in = cap_ff;
      best_v_in = best_v_ff; best_idx_in = best_idx_ff;
      best_cap_in = best_cap_ff; best_own_in = best_own_ff;
      big_v_in = big_v_ff; big_idx_in = big_idx_ff;
      big_cap_in = big_cap_ff; big_own_in = big_own_ff;
      total_in = total_ff; count_in = count_ff; sticky_in = sticky_ff;
      res_owner_in = res_owner_ff; res_cap_in = res_cap_ff; res_code_in = res_code_ff;
      live_we = 1'b0; live_waddr = '0; live_wdata = '0; live_raddr = '0;
      free_we = 1'b0; free_waddr = '0; free_wdata = '0; free_raddr = '0;
      book_we = 1'b0; book_waddr = '0; book_wdata = '0; book_raddr = '0;
      own_we = 1'b0; own_waddr = '0; own_wdata = '0; own_raddr = '0;
      cons_we = 1'b0; cons_waddr = '0; cons_wdata = 1'b0; cons_raddr = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req;
               if (req.new_plan) begin
                  lc_in     = '0;
                  fc_in     = '0;
                  sticky_in = ERR_NONE;
                  total_in  = cfg.base_total_bytes;
                  count_in  = cfg.base_block_count;
                  clr_in    = '0;
                  pend_in   = 1'b1;
               end
            end
         end
         ST_CLEAR: begin
            book_we = 1'b1; book_waddr = clr_ff;
            own_we  = 1'b1; own_waddr  = clr_ff;
            cons_we = 1'b1; cons_waddr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == IDX_LAST) pend_in = 1'b0;
         end
         ST_START: begin
            i_in = '0;
            k_in = '0;
         end
         ST_LRD: begin
            if (i_end) lc_in = k_ff;
            else live_raddr = i_ff[AW-1:0];
         end
         ST_LCHK: begin
            ent_in = live_q;
            if (kept) begin
               live_we    = 1'b1;
               live_waddr = k_ff[AW-1:0];
               live_wdata = live_q;
               k_in       = k_ff + 1'b1;
               i_in       = i_ff + 1'b1;
            end else begin
               cons_raddr = AW'(live_q.buffer - 1'b1);
            end
         end
         ST_CONS: begin
            if (cons_q) i_in = i_ff + 1'b1;
            else j_in = '0;
         end
         ST_DRD: begin
            if (j_end) begin
               if (!fail) begin
                  free_we    = 1'b1;
                  free_waddr = fc_ff[AW-1:0];
                  free_wdata = '{capacity: ent_ff.capacity, owner: ent_ff.owner};
                  fc_in      = fc_ff + 1'b1;
                  i_in       = i_ff + 1'b1;
               end
            end else begin
               free_raddr = j_ff[AW-1:0];
            end
         end
         ST_DCHK: j_in = j_ff + 1'b1;
         ST_PLACE: begin
            if (dest) begin
               own_raddr = AW'(req_ff.source_id - 1'b1);
            end else begin
               j_in      = '0;
               best_v_in = 1'b0;
               big_v_in  = 1'b0;
            end
         end
         ST_ORD: begin
            owner_in   = own_q;
            book_raddr = AW'(own_q - 1'b1);
         end
         ST_BRD: begin
            cap_in = book_q;
            if (!fail) begin
               cons_we    = 1'b1;
               cons_waddr = AW'(req_ff.source_id - 1'b1);
               cons_wdata = 1'b1;
            end
         end
         ST_FRD: if (!j_end) free_raddr = j_ff[AW-1:0];
         ST_FCHK: begin
            if (better_best) begin
               best_v_in   = 1'b1;
               best_idx_in = j_ff[AW-1:0];
               best_cap_in = free_q.capacity;
               best_own_in = free_q.owner;
            end
            if (better_big) begin
               big_v_in   = 1'b1;
               big_idx_in = j_ff[AW-1:0];
               big_cap_in = free_q.capacity;
               big_own_in = free_q.owner;
            end
            j_in = j_ff + 1'b1;
         end
         ST_ALLOC: begin
            if (best_v_ff) begin
               owner_in = best_own_ff;
               cap_in   = best_cap_ff;
               rem_in   = best_idx_ff;
            end else if (grow) begin
               // Grow the largest free block to the request size.
               owner_in = big_own_ff;
               cap_in   = req_ff.request_bytes;
               rem_in   = big_idx_ff;
               if (big_cap_ff < req_ff.request_bytes) begin
                  total_in = sum_ovf ? '1 : sum[TOTAL_W-1:0];
               end
               if (!fail) begin
                  book_we    = 1'b1;
                  book_waddr = AW'(big_own_ff - 1'b1);
                  book_wdata = req_ff.request_bytes;
               end
            end else begin
               // Open a new block owned by the request.
               owner_in = req_ff.buffer_id;
               cap_in   = req_ff.request_bytes;
               total_in = sum_ovf ? '1 : sum[TOTAL_W-1:0];
               if (!fail) begin
                  count_in   = count_ff + 1'b1;
                  book_we    = 1'b1;
                  book_waddr = AW'(req_ff.buffer_id - 1'b1);
                  book_wdata = req_ff.request_bytes;
               end
            end
         end
         ST_REMRD: begin
            fc_in      = fc_dec;
            free_raddr = fc_dec[AW-1:0];
         end
         ST_REMWR: begin
            free_we    = 1'b1;
            free_waddr = rem_ff;
            free_wdata = free_q;
         end
         ST_FIN: book_raddr = AW'(owner_ff - 1'b1);
         ST_FCK: begin
            if (!fail) begin
               own_we     = 1'b1;
               own_waddr  = AW'(req_ff.buffer_id - 1'b1);
               own_wdata  = owner_ff;
               live_we    = 1'b1;
               live_waddr = lc_ff[AW-1:0];
               live_wdata = '{last_use: req_ff.last_use, buffer: req_ff.buffer_id,
                              owner: owner_ff, capacity: cap_ff};
               lc_in        = lc_ff + 1'b1;
               res_owner_in = owner_ff;
               res_cap_in   = cap_ff;
               res_code_in  = ERR_NONE;
            end
         end
         default: ;
      endcase

      // A failing request reports its code; a halted one leaves the sticky code.
      if (fail) begin
         res_owner_in = '0;
         res_cap_in   = '0;
         res_code_in  = fail_code;
         if (fail_code != ERR_HALTED) sticky_in = fail_code;
      end
   end

   // Handshake and result outputs.
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp = '{owner_id: res_owner_ff, granted_bytes: res_cap_ff, total_bytes: total_ff,
                  block_count: count_ff, error_code: res_code_ff};

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         pend_ff   <= 1'b0;
         lc_ff     <= '0;
         fc_ff     <= '0;
         sticky_ff <= ERR_NONE;
         total_ff  <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         pend_ff   <= pend_in;
         lc_ff     <= lc_in;
         fc_ff     <= fc_in;
         sticky_ff <= sticky_in;
         total_ff  <= total_in;
         count_ff  <= count_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      k_ff         <= k_in;
      j_ff         <= j_in;
      rem_ff       <= rem_in;
      req_ff       <= req_in;
      ent_ff       <= ent_in;
      owner_ff     <= owner_in;
      cap_ff       <= cap_in;
      best_v_ff    <= best_v_in;
      best_idx_ff  <= best_idx_in;
      best_cap_ff  <= best_cap_in;
      best_own_ff  <= best_own_in;
      big_v_ff     <= big_v_in;
      big_idx_ff   <= big_idx_in;
      big_cap_ff   <= big_cap_in;
      big_own_ff   <= big_own_in;
      res_owner_ff <= res_owner_in;
      res_cap_ff   <= res_cap_in;
      res_code_ff  <= res_code_in;
   end

`ifndef NO_ASSERTIONS
   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (fc_ff <= CNT_MAX) && (lc_ff <= CNT_MAX))
      else $error("planner table count beyond capacity");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> (state_ff == ST_START) || (state_ff == ST_CLEAR))
      else $error("accepted transaction did not start processing");

   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && (res_code_ff != ERR_NONE) |-> (sticky_ff != ERR_NONE))
      else $error("failed transaction left no sticky error");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LRD) |-> (k_ff <= i_ff))
      else $error("live table compaction overtook its read pointer");
`endif

endmodule

### design/lifetime_buffer_reuse_planner.sv
// Processing time grows with the live entries kept, the entries retired (each checked against the
// free set), the best-fit search over the free set, and a clearing pass when new_plan is set.
// One transaction at a time: the memory sweeps over the live and free tables run through single
// read ports. The result register frees the input side.
// Reset is synchronous and active high; afterwards a clearing pass runs over the bookkeeping
// memories before req_tready rises.
module lifetime_buffer_reuse_planner
   import lbrp_pkg::*;
#(
   parameter int MAX_BUFFERS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // buffer_id, request_bytes, first_use, last_use, source_id
   input  logic                   req_tuser,  // new_plan
   // Result channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // owner_id, granted_bytes, total_bytes, block_count, error_code
   // Configuration write port.
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   req_type req;
   rsp_type core_rsp, out_ff, out_in;
   logic core_rsp_valid, core_rsp_ready, out_valid_ff, out_valid_in;

   // Request unpacking.
   assign req.new_plan      = req_tuser;
   assign req.buffer_id     = req_tdata[8:0];
   assign req.request_bytes = req_tdata[40:9];
   assign req.first_use     = req_tdata[56:41];
   assign req.last_use      = req_tdata[72:57];
   assign req.source_id     = req_tdata[84:73];

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_DESTRUCTIVE: cfg_in.destructive_mode = csr_wdata[0];
            CSR_BASE_TOTAL:  cfg_in.base_total_bytes = csr_wdata[TOTAL_W-1:0];
            CSR_BASE_COUNT:  cfg_in.base_block_count = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   lbrp_ctrl #(.MAX_BUFFERS(MAX_BUFFERS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .rsp_valid (core_rsp_valid),
      .rsp_ready (core_rsp_ready),
      .rsp       (core_rsp)
   );

   // Result register between the planner and the result channel.
   assign core_rsp_ready = !out_valid_ff || rsp_tready;

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (core_rsp_valid && core_rsp_ready) begin
         out_in       = core_rsp;
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.error_code, out_ff.block_count, out_ff.total_bytes,
                        out_ff.granted_bytes, out_ff.owner_id};

endmodule

### verif/tb_top.sv
// Self-checking testbench for the lifetime buffer reuse planner.
// Depends on lbrp_pkg and lifetime_buffer_reuse_planner; predicts every result in-line.
module tb_top;
   import lbrp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBUF = 256;
   localparam logic [TOTAL_W-1:0] TOTAL_TOP = '1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // buffer_id, request_bytes, first_use, last_use, source_id
   logic                   req_tuser = 1'b0;  // new_plan
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // owner_id, granted_bytes, total_bytes, block_count, error_code
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   lifetime_buffer_reuse_planner dut (.*);

   always #6 clock = ~clock;

   // One expected placement outcome.
   typedef struct packed {
      logic [ID_W-1:0]    owner;
      logic [SIZE_W-1:0]  granted;
      logic [TOTAL_W-1:0] total;
      logic [COUNT_W-1:0] count;
      err_type            code;
   } grant_type;

   grant_type grants_due[$];
   int        fail_count = 0;
   int        items_sent = 0;
   int        grants_seen = 0;
   int        faults_seen = 0;

   // Planner shadow state.
   logic               in_place;
   logic [TOTAL_W-1:0] start_total;
   logic [COUNT_W-1:0] start_count;
   logic [TIME_W-1:0]  lv_last [NBUF];
   logic [ID_W-1:0]    lv_buf [NBUF];
   logic [ID_W-1:0]    lv_own [NBUF];
   logic [SIZE_W-1:0]  lv_cap [NBUF];
   int                 lv_n;
   logic [SIZE_W-1:0]  fr_cap [NBUF];
   logic [ID_W-1:0]    fr_own [NBUF];
   int                 fr_n;
   bit                 src_taken [NBUF];
   logic [SIZE_W-1:0]  blk_cap [NBUF];
   logic [ID_W-1:0]    own_tab [NBUF];
   err_type            held_err;
   logic [TOTAL_W-1:0] sum_bytes;
   logic [COUNT_W-1:0] n_blocks;

   function automatic void clear_plan();
      for (int i = 0; i < NBUF; i++) begin
         src_taken[i] = 1'b0;
         blk_cap[i] = '0;
         own_tab[i] = '0;
      end
      lv_n = 0;
      fr_n = 0;
      held_err = ERR_NONE;
      sum_bytes = start_total;
      n_blocks = start_count;
   endfunction

   // Adds to the running total; saturates and returns 0 on overflow.
   function automatic bit grow_total(logic [63:0] delta);
      if (delta > 64'(TOTAL_TOP) - 64'(sum_bytes)) begin
         sum_bytes = TOTAL_TOP;
         return 1'b0;
      end
      sum_bytes = sum_bytes + TOTAL_W'(delta);
      return 1'b1;
   endfunction

   function automatic void drop_free(int k);
      fr_n--;
      fr_cap[k] = fr_cap[fr_n];
      fr_own[k] = fr_own[fr_n];
   endfunction

   // Retires expired buffers and picks a block for one request.
   function automatic err_type place_buffer(int id, logic [SIZE_W-1:0] bytes,
                                            logic [TIME_W-1:0] first, logic [TIME_W-1:0] last,
                                            int src, output logic [ID_W-1:0] owner,
                                            output logic [SIZE_W-1:0] cap);
      int k;
      int b;
      int best;
      int big;
      logic [SIZE_W-1:0] prev;
      k = 0;
      owner = '0;
      cap = '0;
      if (id < 1 || id > NBUF) return ERR_INCONSISTENT;
      for (int i = 0; i < lv_n; i++) begin
         if (lv_last[i] < first) begin
            b = lv_buf[i];
            if (src_taken[b-1]) continue;
            for (int j = 0; j < fr_n; j++)
               if (fr_cap[j] == lv_cap[i] && fr_own[j] == lv_own[i]) return ERR_DUP_FREE;
            if (fr_n >= NBUF) return ERR_INCONSISTENT;
            fr_cap[fr_n] = lv_cap[i];
            fr_own[fr_n] = lv_own[i];
            fr_n++;
         end else begin
            lv_last[k] = lv_last[i];
            lv_buf[k] = lv_buf[i];
            lv_own[k] = lv_own[i];
            lv_cap[k] = lv_cap[i];
            k++;
         end
      end
      lv_n = k;
      if (in_place && src != 0) begin
         if (src > NBUF || own_tab[src-1] == 0) return ERR_BAD_SRC;
         owner = own_tab[src-1];
         cap = blk_cap[owner-1];
         if (cap < bytes) return ERR_SRC_SMALL;
         src_taken[src-1] = 1'b1;
      end else begin
         best = fr_n;
         big = fr_n;
         for (int i = 0; i < fr_n; i++) begin
            if (fr_cap[i] >= bytes && (best == fr_n || fr_cap[i] < fr_cap[best] ||
                (fr_cap[i] == fr_cap[best] && fr_own[i] < fr_own[best])))
               best = i;
            if (big == fr_n || fr_cap[i] > fr_cap[big] ||
                (fr_cap[i] == fr_cap[big] && fr_own[i] > fr_own[big]))
               big = i;
         end
         if (best != fr_n) begin
            cap = fr_cap[best];
            owner = fr_own[best];
            drop_free(best);
         end else if (fr_n != 0) begin
            prev = fr_cap[big];
            owner = fr_own[big];
            drop_free(big);
            cap = bytes;
            if (prev >= cap) return ERR_GROW;
            if (!grow_total(64'(cap - prev))) return ERR_OVERFLOW;
            blk_cap[owner-1] = cap;
         end else begin
            owner = ID_W'(id);
            cap = bytes;
            if (!grow_total(64'(cap))) return ERR_OVERFLOW;
            if (n_blocks >= COUNT_MAX) return ERR_OVERFLOW;
            n_blocks++;
            blk_cap[owner-1] = cap;
         end
      end
      if (owner == 0 || cap == 0 || blk_cap[owner-1] != cap) return ERR_INCONSISTENT;
      if (lv_n >= NBUF) return ERR_INCONSISTENT;
      own_tab[id-1] = owner;
      lv_last[lv_n] = last;
      lv_buf[lv_n] = ID_W'(id);
      lv_own[lv_n] = owner;
      lv_cap[lv_n] = cap;
      lv_n++;
      return ERR_NONE;
   endfunction

   // Works out the result of one accepted request and queues it.
   function automatic void predict_grant(logic fresh, logic [ID_W-1:0] id,
                                         logic [SIZE_W-1:0] bytes, logic [TIME_W-1:0] first,
                                         logic [TIME_W-1:0] last, logic [SRC_W-1:0] src);
      grant_type g;
      if (fresh) clear_plan();
      if (held_err != ERR_NONE) begin
         g.code = ERR_HALTED;
         g.owner = '0;
         g.granted = '0;
      end else begin
         g.code = place_buffer(id, bytes, first, last, src, g.owner, g.granted);
         if (g.code != ERR_NONE) begin
            held_err = g.code;
            g.owner = '0;
            g.granted = '0;
         end
      end
      g.total = sum_bytes;
      g.count = n_blocks;
      grants_due.push_back(g);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 80);
   endfunction

   task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
      fail_count++;
      if (fail_count <= 30)
         $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   // Sends one request; leaves req_tvalid high only when gap is zero.
   task automatic send_req(logic fresh, int id, logic [SIZE_W-1:0] bytes,
                           int first, int last, int src, int gap);
      logic [ID_W-1:0]   f_id;
      logic [TIME_W-1:0] f_first;
      logic [TIME_W-1:0] f_last;
      logic [SRC_W-1:0]  f_src;
      f_id = ID_W'(id);
      f_first = TIME_W'(first);
      f_last = TIME_W'(last);
      f_src = SRC_W'(src);
      req_tvalid <= 1'b1;
      req_tuser <= fresh;
      req_tdata <= REQ_TDATA_W'({f_src, f_last, f_first, bytes, f_id});
      do @(posedge clock); while (!req_tready);
      predict_grant(fresh, f_id, bytes, f_first, f_last, f_src);
      items_sent++;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Stops sending and waits until every expected result has come.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (grants_due.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DESTRUCTIVE: in_place = val[0];
         CSR_BASE_TOTAL:  start_total = val[TOTAL_W-1:0];
         CSR_BASE_COUNT:  start_count = val[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic mode, logic [TOTAL_W-1:0] tot, logic [COUNT_W-1:0] cnt);
      write_csr(CSR_DESTRUCTIVE, CSR_DATA_W'(mode));
      write_csr(CSR_BASE_TOTAL, CSR_DATA_W'(tot));
      write_csr(CSR_BASE_COUNT, CSR_DATA_W'(cnt));
   endtask

   // Best fit, growth, fresh blocks, zero sizes and field extremes.
   task automatic test_reuse();
      set_config(1'b0, '0, '0);
      send_req(1, 1, 100, 0, 2, 0, 0);
      send_req(0, 2, 200, 1, 3, 0, 1);
      send_req(0, 3, 50, 4, 5, 0, 0);
      send_req(0, 4, 300, 4, 9, 0, 2);
      send_req(0, 5, 0, 10, 10, 0, 0);
      send_req(1, 6, 0, 0, 0, 0, 0);
      send_req(0, 7, 10, 1, 1, 0, 1);
      send_req(1, 256, '1, 65535, 65535, 4095, 0);
      send_req(0, 255, 32'h5555_AAAA, 0, 0, 0, 3);
      drain();
   endtask

   // In-place reuse, bad sources, a source too small and a duplicate free.
   task automatic test_in_place();
      set_config(1'b1, 48'd1000, 9'd3);
      send_req(1, 1, 100, 0, 9, 0, 0);
      send_req(0, 2, 80, 1, 9, 1, 0);
      send_req(0, 3, 10, 1, 9, 4095, 0);
      send_req(1, 1, 100, 0, 9, 0, 0);
      send_req(0, 2, 10, 1, 9, 5, 1);
      send_req(1, 1, 10, 0, 9, 0, 0);
      send_req(0, 2, 20, 1, 9, 1, 0);
      send_req(1, 1, 100, 0, 1, 0, 0);
      send_req(0, 2, 50, 5, 6, 1, 0);
      send_req(0, 3, 10, 10, 12, 0, 0);
      send_req(0, 4, 10, 11, 12, 0, 1);
      drain();
   endtask

   // Bad buffer ids, total saturation and block count overflow.
   task automatic test_limits();
      set_config(1'b0, '0, '0);
      send_req(1, 0, 10, 0, 1, 0, 0);
      send_req(1, 511, 10, 0, 1, 0, 1);
      drain();
      set_config(1'b0, TOTAL_TOP - 48'd10, 9'd510);
      send_req(1, 1, 5, 0, 9, 0, 0);
      send_req(0, 2, 100, 0, 9, 0, 0);
      send_req(1, 1, 1, 0, 9, 0, 0);
      send_req(0, 2, 1, 0, 9, 0, 0);
      drain();
      set_config(1'b0, TOTAL_TOP, COUNT_MAX);
      send_req(1, 1, 1, 0, 9, 0, 1);
      drain();
   endtask

   // Fills the live table and overruns it by one.
   task automatic test_table_full();
      set_config(1'b0, '0, '0);
      for (int i = 1; i <= NBUF; i++)
         send_req(i == 1, i, 32'(i), 0, 65535, 0, (i % 37 == 0) ? pick_gap() : 0);
      send_req(0, 1, 1, 0, 65535, 0, 1);
      drain();
   endtask

   // Random plans: mostly well-formed lifetimes with noise mixed in.
   task automatic test_random_plans(int n_items);
      int left;
      int id;
      int t;
      int len;
      int src;
      int id0;
      int burst;
      logic [SIZE_W-1:0] bytes;
      left = n_items;
      burst = 0;
      while (left > 0) begin
         len = $urandom_range(5, 60);
         id0 = $urandom_range(1, NBUF);
         id = id0;
         t = $urandom_range(0, 200);
         if ($urandom_range(0, 9) == 0) t = $urandom_range(60000, 65400);
         for (int i = 0; i < len && left > 0; i++) begin
            bytes = 32'($urandom_range(1, 64) * 16);
            if ($urandom_range(0, 19) == 0) bytes = $urandom();
            src = 0;
            if ($urandom_range(0, 9) < 3) src = $urandom_range(1, NBUF);
            if ($urandom_range(0, 9) < 3 && i > 0)
               src = (id0 + $urandom_range(0, i - 1) - 1) % NBUF + 1;
            if ($urandom_range(0, 39) == 0) src = $urandom_range(0, 4095);
            if ($urandom_range(0, 49) == 0) bytes = '0;
            if ($urandom_range(0, 49) == 0) id = ($urandom_range(0, 1) == 1) ? 0
                                                 : $urandom_range(257, 511);
            if (burst == 0 && $urandom_range(0, 29) == 0) burst = $urandom_range(15, 40);
            send_req(i == 0, id, bytes, t,
                     ($urandom_range(0, 29) == 0) ? $urandom_range(0, 65535)
                                                   : t + $urandom_range(0, 20),
                     src, (burst > 0) ? 0 : pick_gap());
            if (burst > 0) burst--;
            id = (id >= 1 && id < NBUF) ? id + 1 : 1;
            t = t + $urandom_range(0, 3);
            if (t > 65535) t = 65535;
            left--;
         end
         // Now and then the sender holds off until the planner has answered all.
         if ($urandom_range(0, 5) == 0) drain();
      end
      drain();
   endtask

   // Result side stalls: stretches of constant readiness or of random stalls.
   int stall_left = 0;
   int mode_left = 0;
   bit steady = 1'b0;
   always @(negedge clock) begin
      if (mode_left == 0) begin
         steady = ($urandom_range(0, 3) == 0);
         mode_left = $urandom_range(50, 300);
      end else begin
         mode_left--;
      end
      if (steady) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 9) < 7) begin
         rsp_tready <= 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_tready <= 1'b0;
      end
   end

   // Compares each result transaction with the oldest expectation.
   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         grants_seen++;
         if (grants_due.size() == 0) begin
            flag_mismatch("unexpected result", rsp_tdata[63:0], 0);
         end else begin
            want = grants_due.pop_front();
            if (want.code != ERR_NONE) faults_seen++;
            if (rsp_tdata[8:0] != want.owner)
               flag_mismatch("owner_id", rsp_tdata[8:0], want.owner);
            if (rsp_tdata[40:9] != want.granted)
               flag_mismatch("granted_bytes", rsp_tdata[40:9], want.granted);
            if (rsp_tdata[88:41] != want.total)
               flag_mismatch("total_bytes", rsp_tdata[88:41], want.total);
            if (rsp_tdata[97:89] != want.count)
               flag_mismatch("block_count", rsp_tdata[97:89], want.count);
            if (rsp_tdata[100:98] != want.code)
               flag_mismatch("error_code", rsp_tdata[100:98], want.code);
         end
      end
   end

   initial begin
      #(60_000_000);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      in_place = 1'b0;
      start_total = '0;
      start_count = '0;
      clear_plan();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reuse();
      test_in_place();
      test_limits();
      test_table_full();
      set_config(1'b0, 48'd0, 9'd0);
      test_random_plans(200);
      set_config(1'b1, 48'h0000_1234_5678, 9'd100);
      test_random_plans(200);
      set_config(1'b1, TOTAL_TOP - 48'd5000, 9'd256);
      test_random_plans(60);
      set_config(1'b0, 48'd7, 9'd511);
      test_random_plans(80);
      $display("Covered %0d requests and %0d results, %0d of them carrying an error code.",
               items_sent, grants_seen, faults_seen);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
